// ===== hw/rtl/adam_pkg.sv =====
package adam_pkg;

    // Storage depth and the widths that follow from it.
    localparam int MAX_VARS = 64;
    localparam int IDX_W    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int CNT_W    = $clog2(MAX_VARS + 1);
    localparam int COUNT_W  = 7;
    localparam int CW_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Shared divide / square root unit.
    localparam int NUM_W      = 96;
    localparam int DEN_W      = 49;
    localparam int DIV_STEPS  = 96;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = 7;
    localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic signed [50:0] M_MAX = 51'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [50:0] M_MIN = -51'sh0_8000_0000_0000;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_GRAD,
        KIND_READ,
        KIND_NONE
    } t_kind;

    typedef enum logic [2:0] {
        CFG_COUNT,
        CFG_BETA_ONE,
        CFG_BETA_TWO,
        CFG_STEP_SIZE,
        CFG_STABILIZER,
        CFG_MIN_NORM,
        CFG_MAX_NORM
    } t_cfg_idx;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } t_iter_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_G_READ,
        ST_G_P1,
        ST_G_P2,
        ST_G_SQR,
        ST_G_M1,
        ST_G_M2,
        ST_G_V1,
        ST_G_V2,
        ST_G_DIVM,
        ST_G_DIVV,
        ST_G_SQRT,
        ST_G_E1,
        ST_G_E2,
        ST_G_DIVD,
        ST_G_UPD,
        ST_NORM,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/adam_optimizer_step.sv =====
// Channel   Direction  Handshake                  Payload
// s         in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser (kind)
// m         out        o_m_tvalid / i_m_tready    o_m_tdata, o_m_tlast (is_last)
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load item passes through ST_LOAD and ST_OUT, a read item through ST_RD_ADDR,
// ST_RD_DATA and ST_OUT. A gradient element runs three 96-step divisions (two with
// a zero step denominator) and one 32-step root, one bit per cycle on the shared
// unit. The last item of a gradient run, and of a read run after one, adds a
// 32-step norm root. Synchronous active low reset clears control state and valid
// bits. The input is ready only while idle; a stalled output holds.
module adam_optimizer_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [31:0] value, [63:32] evaluation
    input  logic [63:0]   i_s_tdata,
    // [1:0] kind
    input  logic [1:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [31:0] variable, [63:32] best_gradient, [95:64] best_value,
    // [127:96] gradient_norm, [128] stop_low_norm, [129] stop_high_norm
    output logic [135:0]  o_m_tdata,
    output logic          o_m_tlast,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import adam_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0] r_cfg_count;
    logic [31:0] r_beta1, r_beta2, r_eta, r_eps, r_min_norm, r_max_norm;

    // Control and run state.
    t_state r_state, n_state;
    logic [32:0] r_p1, r_p2;
    logic        r_bseen, r_improve, r_gdone;
    logic signed [31:0] r_bobj;
    logic [63:0] r_nacc;
    logic [IDX_W-1:0] r_cnt;
    logic [MAX_VARS-1:0] r_mvalid, r_bgvalid;

    // Current item.
    logic signed [31:0] r_val, r_eval;
    logic [IDX_W-1:0] r_idx;
    logic r_last, r_first;

    // Element datapath.
    logic signed [47:0] r_m;
    logic [63:0] r_v, r_g2, r_vd, r_mhat, r_prod;
    logic signed [31:0] r_cur;
    logic [48:0] r_dmag;
    logic        r_vge;
    logic [31:0] r_tmp;
    logic [48:0] r_den;
    logic [32:0] r_delta;

    // Result being built and the output register.
    logic [31:0] r_res_var, r_res_grad, r_res_norm;
    logic        r_res_lo, r_res_hi;
    logic        r_ovalid, r_olast;
    logic [135:0] r_odata;

    // Memories.
    logic [31:0] cur_q, bv_q, bg_q, cur_wd, bv_wd, bg_wd;
    logic [47:0] m_q, m_wd;
    logic [63:0] v_q, v_wd;
    logic cur_we, bv_we, bg_we, m_we, v_we;

    adam_ram #(.WIDTH(32), .DEPTH(MAX_VARS)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(r_idx), .i_wdata(cur_wd),
        .i_raddr(r_idx), .o_rdata(cur_q));
    adam_ram #(.WIDTH(32), .DEPTH(MAX_VARS)) u_bvar (
        .i_clk(i_clk), .i_we(bv_we), .i_waddr(r_idx), .i_wdata(bv_wd),
        .i_raddr(r_idx), .o_rdata(bv_q));
    adam_ram #(.WIDTH(32), .DEPTH(MAX_VARS)) u_bgrad (
        .i_clk(i_clk), .i_we(bg_we), .i_waddr(r_idx), .i_wdata(bg_wd),
        .i_raddr(r_idx), .o_rdata(bg_q));
    adam_ram #(.WIDTH(48), .DEPTH(MAX_VARS)) u_mom1 (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(r_idx), .i_wdata(m_wd),
        .i_raddr(r_idx), .o_rdata(m_q));
    adam_ram #(.WIDTH(64), .DEPTH(MAX_VARS)) u_mom2 (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(r_idx), .i_wdata(v_wd),
        .i_raddr(r_idx), .o_rdata(v_q));

    // Shared divide / square root unit.
    t_iter_req it_req;
    t_iter_rsp it_rsp;
    logic [NUM_W-1:0] it_num;
    logic [DEN_W-1:0] it_den;
    logic [63:0] it_rad, it_res;

    adam_iter u_iter (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(it_req), .i_num(it_num),
        .i_den(it_den), .i_rad(it_rad), .o_rsp(it_rsp), .o_result(it_res));

    // Item acceptance and the element position.
    logic s_accept;
    t_kind in_kind;
    logic [CW_W-1:0] n_eff, cnt_ext, i_ext;
    logic [IDX_W-1:0] i_sel, i_next;
    logic in_last;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign in_kind    = t_kind'(i_s_tuser);

    always_comb begin
        if (r_cfg_count == '0) begin
            n_eff = CW_W'(1);
        end else if (CW_W'(r_cfg_count) > CW_W'(MAX_VARS)) begin
            n_eff = CW_W'(MAX_VARS);
        end else begin
            n_eff = CW_W'(r_cfg_count);
        end
        cnt_ext = CW_W'(r_cnt);
        i_sel   = (cnt_ext >= n_eff) ? '0 : r_cnt;
        i_ext   = CW_W'(i_sel) + 1'b1;
        in_last = (i_ext == n_eff);
        i_next  = IDX_W'(i_ext);
    end

    // Combinational element arithmetic.
    logic signed [47:0] m_now, g32;
    logic [63:0] v_now;
    logic signed [48:0] dm_diff;
    logic [31:0] gmag;
    logic [64:0] nacc_sum;
    logic [63:0] prod_sum;
    logic signed [50:0] mn_wide;
    logic signed [47:0] mn_sat;
    logic [47:0] mmag;
    logic [63:0] v_new;
    logic [32:0] d1, d2;
    logic [63:0] q_sat;
    logic signed [33:0] nv_wide;
    logic signed [31:0] nv_sat;
    logic [32:0] pw_hi1, pw_hi2;

    always_comb begin
        m_now    = r_mvalid[r_idx] ? $signed(m_q) : '0;
        v_now    = r_mvalid[r_idx] ? v_q : '0;
        g32      = $signed({r_val, 16'b0});
        dm_diff  = $signed({m_now[47], m_now}) - $signed({g32[47], g32});
        gmag     = r_val[31] ? 32'(-r_val) : 32'(r_val);
        nacc_sum = {1'b0, r_nacc} + {1'b0, r_prod};
        prod_sum = r_prod + {32'b0, r_tmp};
        if (r_dmag == '0 || !r_vge) begin
            mn_wide = '0;
        end else begin
            mn_wide = '0;
        end
        // First moment: g + beta1 * (m - g), product magnitude truncated.
        if (r_vge) begin
            mn_wide = $signed({{3{g32[47]}}, g32}) - $signed({2'b0, prod_sum[48:0]});
        end else begin
            mn_wide = $signed({{3{g32[47]}}, g32}) + $signed({2'b0, prod_sum[48:0]});
        end
        if (mn_wide > M_MAX) begin
            mn_sat = M_MAX[47:0];
        end else if (mn_wide < M_MIN) begin
            mn_sat = M_MIN[47:0];
        end else begin
            mn_sat = mn_wide[47:0];
        end
        mmag  = r_m[47] ? 48'(-r_m) : 48'(r_m);
        v_new = r_vge ? (r_g2 + prod_sum) : (r_g2 - prod_sum);
        d1 = ONE_Q32 - r_p1;
        if (d1 == '0) begin
            d1 = 33'd1;
        end
        d2 = ONE_Q32 - r_p2;
        if (d2 == '0) begin
            d2 = 33'd1;
        end
        q_sat   = it_rsp.sat ? '1 : it_res;
        nv_wide = r_dmag[0] ? ($signed({{2{r_cur[31]}}, r_cur}) - $signed({1'b0, r_delta}))
                            : ($signed({{2{r_cur[31]}}, r_cur}) + $signed({1'b0, r_delta}));
        if (nv_wide > 34'sh0_7FFF_FFFF) begin
            nv_sat = 32'sh7FFF_FFFF;
        end else if (nv_wide < -34'sh0_8000_0000) begin
            nv_sat = 32'sh8000_0000;
        end else begin
            nv_sat = nv_wide[31:0];
        end
        pw_hi1 = r_p1[32] ? {1'b0, r_beta1} : '0;
        pw_hi2 = r_p2[32] ? {1'b0, r_beta2} : '0;
    end

    // Multiplier operands by sequencer step; the product is registered.
    logic [31:0] mul_a, mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_G_READ: begin
                mul_a = r_p1[31:0];
                mul_b = r_beta1;
            end
            ST_G_P1: begin
                mul_a = r_p2[31:0];
                mul_b = r_beta2;
            end
            ST_G_P2: begin
                mul_a = gmag;
                mul_b = gmag;
            end
            ST_G_SQR: begin
                mul_a = r_dmag[32:1];
                mul_b = r_beta1;
            end
            ST_G_M1: begin
                mul_a = {16'b0, r_dmag[48:33]};
                mul_b = r_beta1;
            end
            ST_G_M2: begin
                mul_a = r_vd[31:0];
                mul_b = r_beta2;
            end
            ST_G_V1: begin
                mul_a = r_vd[63:32];
                mul_b = r_beta2;
            end
            ST_G_SQRT: begin
                mul_a = r_mhat[31:0];
                mul_b = r_eta;
            end
            ST_G_E1: begin
                mul_a = r_mhat[63:32];
                mul_b = r_eta;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state, memory writes and unit requests.
    always_comb begin
        n_state = r_state;
        it_req  = '{start: 1'b0, mode: ITER_DIV};
        it_num  = '0;
        it_den  = '0;
        it_rad  = '0;
        cur_we = 1'b0; cur_wd = r_val;
        bv_we  = 1'b0; bv_wd  = r_val;
        bg_we  = 1'b0; bg_wd  = r_val;
        m_we   = 1'b0; m_wd   = mn_sat;
        v_we   = 1'b0; v_wd   = v_new;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_kind)
                        KIND_LOAD: n_state = ST_LOAD;
                        KIND_GRAD: n_state = ST_G_READ;
                        KIND_READ: n_state = ST_RD_ADDR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                cur_we  = 1'b1;
                bv_we   = 1'b1;
                n_state = ST_OUT;
            end
            ST_RD_ADDR: n_state = ST_RD_DATA;
            ST_RD_DATA: begin
                if (r_last && r_gdone) begin
                    it_req  = '{start: 1'b1, mode: ITER_SQRT};
                    it_rad  = r_nacc;
                    n_state = ST_NORM;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_G_READ: n_state = ST_G_P1;
            ST_G_P1: begin
                // Snapshot the point before it moves when the run improved.
                if (r_improve) begin
                    bv_we = 1'b1;
                    bv_wd = cur_q;
                    bg_we = 1'b1;
                end
                n_state = ST_G_P2;
            end
            ST_G_P2:  n_state = ST_G_SQR;
            ST_G_SQR: n_state = ST_G_M1;
            ST_G_M1:  n_state = ST_G_M2;
            ST_G_M2: begin
                m_we    = 1'b1;
                n_state = ST_G_V1;
            end
            ST_G_V1: n_state = ST_G_V2;
            ST_G_V2: begin
                v_we    = 1'b1;
                it_req  = '{start: 1'b1, mode: ITER_DIV};
                it_num  = {16'b0, mmag, 32'b0};
                it_den  = {16'b0, d1};
                n_state = ST_G_DIVM;
            end
            ST_G_DIVM: begin
                if (it_rsp.done) begin
                    it_req  = '{start: 1'b1, mode: ITER_DIV};
                    it_num  = {r_v, 32'b0};
                    it_den  = {16'b0, d2};
                    n_state = ST_G_DIVV;
                end
            end
            ST_G_DIVV: begin
                if (it_rsp.done) begin
                    it_req  = '{start: 1'b1, mode: ITER_SQRT};
                    it_rad  = q_sat;
                    n_state = ST_G_SQRT;
                end
            end
            ST_G_SQRT: begin
                if (it_rsp.done) begin
                    n_state = ST_G_E1;
                end
            end
            ST_G_E1: n_state = ST_G_E2;
            ST_G_E2: begin
                if (r_den == '0) begin
                    n_state = ST_G_UPD;
                end else begin
                    it_req  = '{start: 1'b1, mode: ITER_DIV};
                    it_num  = {16'b0, prod_sum, 16'b0};
                    it_den  = r_den;
                    n_state = ST_G_DIVD;
                end
            end
            ST_G_DIVD: begin
                if (it_rsp.done) begin
                    n_state = ST_G_UPD;
                end
            end
            ST_G_UPD: begin
                cur_we = 1'b1;
                cur_wd = nv_sat;
                if (r_last) begin
                    it_req  = '{start: 1'b1, mode: ITER_SQRT};
                    it_rad  = r_nacc;
                    n_state = ST_NORM;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_NORM: begin
                if (it_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes; the port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= COUNT_W'(1);
            r_beta1     <= 32'd3865470566;
            r_beta2     <= 32'd4290672329;
            r_eta       <= 32'd4294967;
            r_eps       <= 32'd43;
            r_min_norm  <= 32'd0;
            r_max_norm  <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COUNT:      r_cfg_count <= i_cfg_data[COUNT_W-1:0];
                CFG_BETA_ONE:   r_beta1     <= i_cfg_data;
                CFG_BETA_TWO:   r_beta2     <= i_cfg_data;
                CFG_STEP_SIZE:  r_eta       <= i_cfg_data;
                CFG_STABILIZER: r_eps       <= i_cfg_data;
                CFG_MIN_NORM:   r_min_norm  <= i_cfg_data;
                CFG_MAX_NORM:   r_max_norm  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1      <= ONE_Q32;
            r_p2      <= ONE_Q32;
            r_bseen   <= 1'b0;
            r_bobj    <= '0;
            r_improve <= 1'b0;
            r_gdone   <= 1'b0;
            r_nacc    <= '0;
            r_cnt     <= '0;
            r_mvalid  <= '0;
            r_bgvalid <= '0;
        end else begin
            if (s_accept && in_kind != KIND_NONE) begin
                r_cnt <= in_last ? '0 : i_next;
            end
            case (r_state)
                ST_LOAD: begin
                    // A cleared valid bit reads back as a zero moment.
                    r_mvalid[r_idx]  <= 1'b0;
                    r_bgvalid[r_idx] <= 1'b0;
                    if (r_first) begin
                        r_p1    <= ONE_Q32;
                        r_p2    <= ONE_Q32;
                        r_bseen <= 1'b0;
                        r_gdone <= 1'b0;
                        r_nacc  <= '0;
                    end
                end
                ST_G_READ: begin
                    if (r_first) begin
                        r_nacc <= '0;
                        if (!r_bseen || r_eval > r_bobj) begin
                            r_improve <= 1'b1;
                            r_bobj    <= r_eval;
                            r_bseen   <= 1'b1;
                        end else begin
                            r_improve <= 1'b0;
                        end
                    end
                end
                ST_G_P1: begin
                    if (r_first) begin
                        r_p1 <= pw_hi1 + {1'b0, r_prod[63:32]};
                    end
                    if (r_improve) begin
                        r_bgvalid[r_idx] <= 1'b1;
                    end
                end
                ST_G_P2: begin
                    if (r_first) begin
                        r_p2 <= pw_hi2 + {1'b0, r_prod[63:32]};
                    end
                end
                ST_G_SQR: begin
                    r_nacc <= nacc_sum[64] ? '1 : nacc_sum[63:0];
                end
                ST_G_M2: begin
                    r_mvalid[r_idx] <= 1'b1;
                end
                ST_G_UPD: begin
                    if (r_last) begin
                        r_gdone <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item and element datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        if (s_accept) begin
            r_val      <= $signed(i_s_tdata[31:0]);
            r_eval     <= $signed(i_s_tdata[63:32]);
            r_idx      <= i_sel;
            r_last     <= in_last;
            r_first    <= (i_sel == '0);
            r_res_grad <= '0;
            r_res_norm <= '0;
            r_res_lo   <= 1'b0;
            r_res_hi   <= 1'b0;
        end
        case (r_state)
            ST_LOAD: r_res_var <= r_val;
            ST_RD_DATA: begin
                r_res_var  <= bv_q;
                r_res_grad <= r_bgvalid[r_idx] ? bg_q : '0;
            end
            ST_G_P1: begin
                r_m    <= m_now;
                r_v    <= v_now;
                r_cur  <= $signed(cur_q);
                // Bit 0 carries the sign of the moment difference until the
                // magnitude products are done.
                r_dmag <= {dm_diff[48] ? 48'(-dm_diff) : 48'(dm_diff), dm_diff[48]};
                r_vge  <= dm_diff[48];
            end
            ST_G_SQR: begin
                r_g2 <= r_prod;
                if (r_v >= r_prod) begin
                    r_vd <= r_v - r_prod;
                end else begin
                    r_vd <= r_prod - r_v;
                end
                r_tmp <= '0;
            end
            ST_G_M1: r_tmp <= r_prod[63:32];
            ST_G_M2: begin
                r_m   <= mn_sat;
                r_vge <= (r_v >= r_g2);
            end
            ST_G_V1: r_tmp <= r_prod[63:32];
            ST_G_V2: begin
                r_v    <= v_new;
                r_dmag <= {48'b0, r_m[47]};
            end
            ST_G_DIVM: begin
                if (it_rsp.done) begin
                    r_mhat <= q_sat;
                end
            end
            ST_G_SQRT: begin
                if (it_rsp.done) begin
                    r_den <= {1'b0, it_res[31:0], 16'b0} + {17'b0, r_eps};
                end
                r_tmp <= '0;
            end
            ST_G_E1: r_tmp <= r_prod[63:32];
            ST_G_E2: begin
                if (r_den == '0) begin
                    r_delta <= '0;
                end
            end
            ST_G_DIVD: begin
                if (it_rsp.done) begin
                    r_delta <= (q_sat > 64'(ONE_Q32)) ? ONE_Q32 : q_sat[32:0];
                end
            end
            ST_G_UPD: r_res_var <= nv_sat;
            ST_NORM: begin
                if (it_rsp.done) begin
                    r_res_norm <= it_res[31:0];
                    r_res_lo   <= (it_res[31:0] <= r_min_norm);
                    r_res_hi   <= (it_res[31:0] >= r_max_norm);
                end
            end
            default: ;
        endcase
    end

    // Output register: holds a finished item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_OUT && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ovalid || i_m_tready)) begin
            r_olast <= r_last;
            r_odata <= {6'b0, r_res_hi, r_res_lo, r_res_norm,
                        (r_bseen ? r_bobj : 32'sh8000_0000),
                        r_res_grad, r_res_var};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

// ===== hw/rtl/adam_ram.sv =====
module adam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/adam_iter.sv =====
module adam_iter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  adam_pkg::t_iter_req       i_req,
    input  logic [adam_pkg::NUM_W-1:0] i_num,
    input  logic [adam_pkg::DEN_W-1:0] i_den,
    input  logic [63:0]               i_rad,
    output adam_pkg::t_iter_rsp       o_rsp,
    output logic [63:0]               o_result
);
    import adam_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic             r_sat;
    t_iter_mode       r_mode;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [63:0]      r_rem;
    logic [63:0]      r_acc;

    logic [64:0]      sub_a;
    logic [64:0]      sub_b;
    logic [64:0]      diff;
    logic             ge;
    logic             last_step;

    // One subtractor serves both the restoring divide and the root.
    always_comb begin
        if (r_mode == ITER_DIV) begin
            sub_a = {15'b0, r_rem[DEN_W-1:0], r_num[NUM_W-1]};
            sub_b = {16'b0, r_den};
            last_step = (r_step == STEP_W'(DIV_STEPS - 1));
        end else begin
            sub_a = {1'b0, r_rem};
            sub_b = {1'b0, r_acc + r_num[63:0]};
            last_step = (r_step == STEP_W'(SQRT_STEPS - 1));
        end
        diff = sub_a - sub_b;
        ge   = ~diff[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= ITER_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_step <= '0;
                r_sat  <= 1'b0;
                r_acc  <= '0;
                r_den  <= i_den;
                if (i_req.mode == ITER_DIV) begin
                    r_rem <= '0;
                    r_num <= i_num;
                end else begin
                    r_rem <= i_rad;
                    r_num <= {32'b0, SQRT_TOP_BIT};
                end
            end else if (r_busy) begin
                r_rem  <= ge ? diff[63:0] : sub_a[63:0];
                r_step <= r_step + 1'b1;
                if (r_mode == ITER_DIV) begin
                    if (r_acc[63]) begin
                        r_sat <= 1'b1;
                    end
                    r_acc <= {r_acc[62:0], ge};
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                end else begin
                    r_acc <= ge ? ((r_acc >> 1) + r_num[63:0]) : (r_acc >> 1);
                    r_num <= r_num >> 2;
                end
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_result   = r_acc;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adam_pkg::*;

    // Idle cycles allowed before the run is declared hung. It must outlast a gradient
    // element and the long output hold-off.
    localparam int WATCHDOG_LIMIT = 20000;
    // Worst case for one item still in flight: gradient element plus norm root.
    localparam int SETTLE_CYCLES  = 500;
    localparam int HOLD_CYCLES    = 3000;
    localparam logic [63:0] UNITY = 64'h1_0000_0000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [135:0] o_m_tdata;
    logic         o_m_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    adam_optimizer_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One expected output item.
    typedef struct {
        logic [31:0] variable;
        logic [31:0] best_grad;
        logic [31:0] best_val;
        logic [31:0] norm;
        logic        last;
        logic        low;
        logic        high;
    } t_step_result;

    t_step_result pending_steps[$];
    int           mismatches;
    int           items_sent;
    bit           no_gaps;
    logic         hold_go;
    int           hold_left;

    // Shadow copy of the optimizer: configuration and state.
    logic [6:0]          sh_count;
    logic [31:0]         sh_beta1, sh_beta2, sh_eta, sh_eps, sh_min, sh_max;
    logic signed [31:0]  sh_var[MAX_VARS];
    logic signed [31:0]  sh_best_var[MAX_VARS];
    logic signed [31:0]  sh_best_grad[MAX_VARS];
    logic signed [63:0]  sh_mom1[MAX_VARS];
    logic [63:0]         sh_mom2[MAX_VARS];
    logic signed [31:0]  sh_best_obj;
    bit                  sh_best_seen;
    logic [63:0]         sh_pow1, sh_pow2;
    int unsigned         sh_elem;
    logic [63:0]         sh_norm_acc;
    bit                  sh_improve;
    bit                  sh_grad_done;

    // floor(a * f / 2^32)
    function automatic logic [63:0] frac_mul(logic [63:0] a, logic [31:0] f);
        logic [95:0] p;
        p = {32'b0, a} * {64'b0, f};
        return p[95:32];
    endfunction

    // floor(a * 2^sh / d), saturating at 2^64-1.
    function automatic logic [63:0] shift_div(logic [63:0] a, int sh, logic [63:0] d);
        logic [127:0] q;
        q = ({64'b0, a} << sh) / {64'b0, d};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic void reset_shadow();
        sh_count = 7'd1;
        sh_beta1 = 32'd3865470566;
        sh_beta2 = 32'd4290672329;
        sh_eta   = 32'd4294967;
        sh_eps   = 32'd43;
        sh_min   = 32'd0;
        sh_max   = 32'hFFFF_FFFF;
        for (int k = 0; k < MAX_VARS; k++) begin
            sh_var[k] = 0;
            sh_best_var[k] = 0;
            sh_best_grad[k] = 0;
            sh_mom1[k] = 0;
            sh_mom2[k] = 0;
        end
        sh_best_obj = 0;
        sh_best_seen = 0;
        sh_pow1 = UNITY;
        sh_pow2 = UNITY;
        sh_elem = 0;
        sh_norm_acc = 0;
        sh_improve = 0;
        sh_grad_done = 0;
    endfunction

    // Moment update, bias correction and one ascent step for element i.
    function automatic logic signed [31:0] ascend(int i, logic signed [63:0] g);
        logic signed [63:0] g32, diff, mn, nv;
        logic [63:0] dmag, prod, gmag, g2, v, d1, d2, mmag, mhat, vhat, r, den, delta;
        g32 = g <<< 16;
        diff = sh_mom1[i] - g32;
        dmag = (diff < 0) ? -diff : diff;
        prod = frac_mul(dmag, sh_beta1);
        gmag = (g < 0) ? -g : g;
        g2 = gmag * gmag;
        v = sh_mom2[i];
        mn = (diff < 0) ? g32 - $signed(prod) : g32 + $signed(prod);
        if (mn > 64'sh7FFF_FFFF_FFFF) mn = 64'sh7FFF_FFFF_FFFF;
        if (mn < -64'sh8000_0000_0000) mn = -64'sh8000_0000_0000;
        sh_mom1[i] = mn;
        if (v >= g2) v = g2 + frac_mul(v - g2, sh_beta2);
        else v = g2 - frac_mul(g2 - v, sh_beta2);
        sh_mom2[i] = v;
        if (~sh_norm_acc < g2) sh_norm_acc = '1;
        else sh_norm_acc = sh_norm_acc + g2;
        d1 = UNITY - sh_pow1;
        if (d1 == 0) d1 = 1;
        d2 = UNITY - sh_pow2;
        if (d2 == 0) d2 = 1;
        mmag = (mn < 0) ? -mn : mn;
        mhat = shift_div(mmag, 32, d1);
        vhat = shift_div(v, 32, d2);
        r = root64(vhat);
        den = (r << 16) + {32'b0, sh_eps};
        // With a zero root and no stabilizer the step is simply dropped.
        delta = (den == 0) ? 64'd0 : shift_div(frac_mul(mhat, sh_eta), 16, den);
        if (delta > UNITY) delta = UNITY;
        nv = 64'(sh_var[i]);
        nv = (mn < 0) ? nv - $signed(delta) : nv + $signed(delta);
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        sh_var[i] = nv[31:0];
        return nv[31:0];
    endfunction

    // Advance the shadow optimizer by one accepted item and queue its result.
    function automatic void predict_step(t_kind kind, logic signed [31:0] val,
                                         logic signed [31:0] ev);
        t_step_result res;
        int unsigned n, i;
        bit last, report;
        logic [63:0] nrm;
        if (kind == KIND_NONE) return;
        n = (sh_count == 0) ? 1 : ((sh_count > MAX_VARS) ? MAX_VARS : sh_count);
        i = (sh_elem >= n) ? 0 : sh_elem;
        last = (i + 1 == n);
        report = 0;
        res.variable = 0;
        res.best_grad = 0;
        case (kind)
            KIND_LOAD: begin
                if (i == 0) begin
                    sh_pow1 = UNITY;
                    sh_pow2 = UNITY;
                    sh_best_seen = 0;
                    sh_grad_done = 0;
                    sh_norm_acc = 0;
                end
                sh_var[i] = val;
                sh_best_var[i] = val;
                sh_best_grad[i] = 0;
                sh_mom1[i] = 0;
                sh_mom2[i] = 0;
                res.variable = val;
            end
            KIND_GRAD: begin
                if (i == 0) begin
                    sh_pow1 = frac_mul(sh_pow1, sh_beta1);
                    sh_pow2 = frac_mul(sh_pow2, sh_beta2);
                    sh_norm_acc = 0;
                    sh_improve = !sh_best_seen || (ev > sh_best_obj);
                    if (sh_improve) begin
                        sh_best_obj = ev;
                        sh_best_seen = 1;
                    end
                end
                if (sh_improve) begin
                    sh_best_var[i] = sh_var[i];
                    sh_best_grad[i] = val;
                end
                res.variable = ascend(i, 64'(val));
                if (last) begin
                    sh_grad_done = 1;
                    report = 1;
                end
            end
            default: begin
                res.variable = sh_best_var[i];
                res.best_grad = sh_best_grad[i];
                if (last && sh_grad_done) report = 1;
            end
        endcase
        nrm = report ? root64(sh_norm_acc) : 64'd0;
        res.norm = nrm[31:0];
        res.low = report && (nrm <= {32'b0, sh_min});
        res.high = report && (nrm >= {32'b0, sh_max});
        res.best_val = sh_best_seen ? sh_best_obj : 32'h8000_0000;
        res.last = last;
        sh_elem = last ? 0 : i + 1;
        pending_steps.insert(pending_steps.size(), res);
    endfunction

    function automatic void apply_register(t_cfg_idx idx, logic [31:0] data);
        case (idx)
            CFG_COUNT:      sh_count = data[6:0];
            CFG_BETA_ONE:   sh_beta1 = data;
            CFG_BETA_TWO:   sh_beta2 = data;
            CFG_STEP_SIZE:  sh_eta = data;
            CFG_STABILIZER: sh_eps = data;
            CFG_MIN_NORM:   sh_min = data;
            CFG_MAX_NORM:   sh_max = data;
            default: ;
        endcase
    endfunction

    // A Q16.16 value drawn from a mix of full-range, moderate and edge values.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    // Offer one input item after a random gap and wait until it is taken.
    // We are always at a rising edge on entry and on return.
    task automatic send_item(t_kind kind, logic [31:0] val, logic [31:0] ev);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {ev, val};
        do @(posedge i_clk); while (!o_s_tready);
        predict_step(kind, val, ev);
        if (kind != KIND_NONE) items_sent++;
    endtask

    // Wait until the block is idle, then write one register.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        // An ignored item may still be in the sequencer with nothing queued.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_register(idx, data);
    endtask

    task automatic write_all(logic [6:0] cnt, logic [31:0] b1, logic [31:0] b2,
                             logic [31:0] eta, logic [31:0] eps,
                             logic [31:0] lo, logic [31:0] hi);
        write_reg(CFG_COUNT, {25'b0, cnt});
        write_reg(CFG_BETA_ONE, b1);
        write_reg(CFG_BETA_TWO, b2);
        write_reg(CFG_STEP_SIZE, eta);
        write_reg(CFG_STABILIZER, eps);
        write_reg(CFG_MIN_NORM, lo);
        write_reg(CFG_MAX_NORM, hi);
    endtask

    // A whole run of one kind with random content.
    task automatic send_run(t_kind kind, int len);
        for (int k = 0; k < len; k++) begin
            send_item(kind, pick_value(), $urandom_range(0, 3) == 0 ? pick_value() : $urandom());
        end
    endtask

    // Every entry gets written first, so no read ever hits an unwritten entry.
    task automatic test_fill_all_entries();
        write_reg(CFG_COUNT, MAX_VARS);
        send_run(KIND_LOAD, MAX_VARS);
    endtask

    // Field extremes on a short run: loads, gradients and reads.
    task automatic test_directed_extremes();
        write_reg(CFG_COUNT, 32'd4);
        send_item(KIND_LOAD, 32'h7FFF_FFFF, 32'h0);
        send_item(KIND_LOAD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(KIND_LOAD, 32'h0, 32'h0);
        send_item(KIND_LOAD, 32'h0001_0000, 32'h7FFF_FFFF);
        send_item(KIND_GRAD, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(KIND_GRAD, 32'h8000_0000, 32'h0);
        send_item(KIND_GRAD, 32'h0, 32'h0);
        send_item(KIND_GRAD, 32'h0000_0001, 32'h0);
        // A higher objective snapshots the current point.
        send_item(KIND_GRAD, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send_item(KIND_GRAD, 32'h0002_8000, 32'h0);
        send_item(KIND_GRAD, 32'h0000_0000, 32'h0);
        send_item(KIND_GRAD, 32'hFFFF_FFFF, 32'h0);
        send_run(KIND_READ, 4);
    endtask

    // With no stabilizer and a zero second moment the step must vanish.
    task automatic test_zero_denominator();
        write_reg(CFG_STABILIZER, 32'd0);
        send_run(KIND_LOAD, 4);
        send_item(KIND_GRAD, 32'h0, 32'h1234_0000);
        send_item(KIND_GRAD, 32'h0, 32'h0);
        send_item(KIND_GRAD, 32'h0, 32'h0);
        send_item(KIND_GRAD, 32'h0, 32'h0);
        write_reg(CFG_STABILIZER, 32'd43);
    endtask

    // Counts outside the legal range, mixed kinds in one run and the unused kind.
    task automatic test_count_and_kinds();
        write_reg(CFG_COUNT, 32'd0);
        send_item(KIND_GRAD, 32'h0001_0000, 32'h0);
        send_item(KIND_READ, 32'h0, 32'h0);
        write_reg(CFG_COUNT, 32'd3);
        send_item(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_GRAD, 32'h0000_8000, 32'h0001_0000);
        send_item(KIND_READ, 32'h0, 32'h0);
        send_item(KIND_LOAD, 32'h0003_0000, 32'h0);
        // These gradients leave the counter beyond a smaller count, which must wrap to element zero.
        send_item(KIND_GRAD, 32'h0, 32'h0);
        send_item(KIND_GRAD, 32'h0, 32'h0);
        write_reg(CFG_COUNT, 32'd1);
        send_item(KIND_READ, 32'h0, 32'h0);
        write_reg(CFG_COUNT, 32'd127);
        send_run(KIND_READ, MAX_VARS);
    endtask

    // Hold the output off for a long time while items keep coming in.
    task automatic test_output_backpressure();
        write_reg(CFG_COUNT, 32'd5);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        send_run(KIND_LOAD, 5);
        send_run(KIND_READ, 5);
        send_run(KIND_GRAD, 5);
    endtask

    // Random runs over a sweep of register settings, extremes included.
    task automatic test_random_runs();
        int target;
        int sel;
        int len;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_all(7'd4, 32'd3865470566, 32'd4290672329, 32'd4294967, 32'd43,
                             32'd0, 32'hFFFF_FFFF);
                1: write_all(7'd3, 32'd0, 32'd0, 32'h1000_0000, 32'd1,
                             32'h0001_0000, 32'h0010_0000);
                2: write_all(7'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                             32'hFFFF_FFFF, 32'd0);
                3: write_all(7'd2, 32'h8000_0000, 32'hF000_0000, 32'd0, 32'hFFFF_FFFF,
                             32'h0000_8000, 32'h0100_0000);
                4: write_all(7'd64, 32'd3865470566, 32'd4290672329, 32'h0100_0000,
                             32'd43, 32'h0004_0000, 32'h0040_0000);
                default: write_all(7'($urandom_range(1, 8)), $urandom(), $urandom(),
                                   $urandom(), $urandom(), $urandom_range(0, 32'h0008_0000),
                                   $urandom());
            endcase
            target = items_sent + 60;
            while (items_sent < target) begin
                no_gaps = ($urandom_range(0, 4) == 0);
                len = (sh_count == 0) ? 1 : ((sh_count > MAX_VARS) ? MAX_VARS : sh_count);
                sel = $urandom_range(0, 19);
                if (sel < 3) begin
                    send_run(KIND_LOAD, len);
                end else if (sel < 15) begin
                    send_run(KIND_GRAD, len);
                end else if (sel < 18) begin
                    send_run(KIND_READ, len);
                end else begin
                    // Noise: any kind, the unused one included, in any order.
                    for (int k = 0; k < len; k++) begin
                        send_item(t_kind'($urandom_range(0, 3)), pick_value(), $urandom());
                    end
                end
            end
            no_gaps = 0;
        end
    endtask

    // Receiver: random hold-off after every taken item, plus the long hold.
    always @(posedge i_clk) begin : rx_side
        int gap;
        int rx_wait;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait = 0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
        end else if (i_m_tready && o_m_tvalid) begin
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            rx_wait = gap;
            i_m_tready <= (gap == 0);
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
            i_m_tready <= (rx_wait == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) hold_left <= 0;
        else if (hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
                     expected, actual);
            mismatches++;
        end
    endtask

    // Every output item is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_step_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected output item, expected none, actual %h", $realtime,
                         o_m_tdata);
                mismatches++;
            end else begin
                exp_res = pending_steps.pop_front();
                check_field("variable", exp_res.variable, o_m_tdata[31:0]);
                check_field("best_gradient", exp_res.best_grad, o_m_tdata[63:32]);
                check_field("best_value", exp_res.best_val, o_m_tdata[95:64]);
                check_field("gradient_norm", exp_res.norm, o_m_tdata[127:96]);
                check_field("stop_low_norm", 32'(exp_res.low), 32'(o_m_tdata[128]));
                check_field("stop_high_norm", 32'(exp_res.high), 32'(o_m_tdata[129]));
                check_field("is_last", 32'(exp_res.last), 32'(o_m_tlast));
            end
        end
    end

    // Ends a hung run: counts cycles in which no channel moves anything.
    always @(posedge i_clk) begin : watchdog
        int idle;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle = 0;
        end else begin
            idle = idle + 1;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= KIND_LOAD;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= '0;
        hold_go     <= 1'b0;
        mismatches = 0;
        items_sent = 0;
        no_gaps = 0;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_all_entries();
        test_directed_extremes();
        test_zero_denominator();
        test_count_and_kinds();
        test_output_backpressure();
        test_random_runs();

        i_s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_steps.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/adam_pkg.sv
hw/rtl/adam_ram.sv
hw/rtl/adam_iter.sv
hw/rtl/adam_optimizer_step.sv
sim/testbench.sv
